@@ design/csvt_pkg.sv @@
`default_nettype none
package csvt_pkg;

  localparam int MAX_COLUMNS_DEF = 32;
  localparam int RESULT_CAP      = 32;
  localparam int COL_W           = 5;
  localparam int RUN_W           = $clog2(RESULT_CAP + 1);

  localparam logic [7:0] BYTE_NL    = 8'd10;
  localparam logic [7:0] BYTE_COMMA = 8'h2C;
  localparam logic [7:0] BYTE_QUOTE = 8'h22;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  // A fill result stands in for a field missing from a short row.
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_FILL = 2'd2,
    KIND_DROP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_PLAIN       = 2'd0,
    MODE_QUOTED      = 2'd1,
    MODE_AFTER_QUOTE = 2'd2,
    MODE_SPACE       = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CLOSE = 2'd1,
    ST_FILL  = 2'd2
  } state_t;

  typedef struct packed {
    logic take;
    logic close;
    logic fill;
  } cmd_t;

  typedef struct packed {
    logic slot_ok;
    logic close_req;
    logic fill_after;
    logic fill_last;
  } status_t;

endpackage
`default_nettype wire

@@ design/csvt_ctrl.sv @@
`default_nettype none
module csvt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire csvt_pkg::status_t st,
  output csvt_pkg::cmd_t         cmd,
  output logic                   in_stall
);
  import csvt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && st.slot_ok && st.close_req) state_nxt = ST_CLOSE;
      end
      ST_CLOSE: begin
        if (st.slot_ok) state_nxt = st.fill_after ? ST_FILL : ST_IDLE;
      end
      ST_FILL: begin
        if (st.slot_ok && st.fill_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = !st.slot_ok;
        cmd.take = in_valid && st.slot_ok;
      end
      ST_CLOSE: cmd.close = st.slot_ok;
      ST_FILL:  cmd.fill  = st.slot_ok;
      default:  cmd       = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/csvt_dp.sv @@
`default_nettype none
module csvt_dp #(
  parameter int MAX_COLUMNS = csvt_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire csvt_pkg::cmd_t              cmd,
  output csvt_pkg::status_t                st,
  input  wire logic [7:0]                  in_byte_value,
  input  wire logic                        in_end_of_stream,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_result_kind,
  output logic [7:0]                       out_field_byte,
  output logic [csvt_pkg::COL_W-1:0]       out_column_index,
  output logic                             out_header_row,
  output logic                             out_column_overflow,
  output logic                             out_last_of_run
);
  import csvt_pkg::*;

  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int FILL_W = $clog2(MAX_COLUMNS + 2);
  localparam logic [CNT_W-1:0] COL_MAX = CNT_W'(MAX_COLUMNS);
  localparam logic [CNT_W-1:0] COL_TOP = CNT_W'(MAX_COLUMNS - 1);

  mode_t              mode_r, mode_nxt;
  logic [CNT_W-1:0]   col_r, col_nxt;
  logic [CNT_W-1:0]   exp_r, exp_nxt;
  logic               hdr_seen_r, hdr_seen_nxt;
  logic [FILL_W-1:0]  fill_col_r, fill_col_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;

  logic               ov_r;
  kind_t              kind_r;
  logic [7:0]         byte_r;
  logic [COL_W-1:0]   idx_r;
  logic               hdr_r;
  logic               ovf_r;
  logic               last_r;

  logic               t_emit;
  kind_t              t_kind;
  logic [7:0]         t_byte;
  mode_t              t_mode;
  logic               t_adv;
  logic [CNT_W-1:0]   col_inc;
  logic               col_sat;
  logic [CNT_W-1:0]   col_idx;
  logic               close_q;
  logic [FILL_W-1:0]  close_start;
  logic [CNT_W-1:0]   close_count;
  logic [FILL_W-1:0]  exp_ext;

  logic               load;
  kind_t              e_kind;
  logic [7:0]         e_byte;
  logic [COL_W-1:0]   e_idx;
  logic               e_ovf;
  logic               e_last;

  assign col_sat = (col_r >= COL_MAX);
  assign col_inc = col_sat ? COL_MAX : col_r + 1'b1;
  assign col_idx = col_sat ? COL_TOP : col_r;
  assign close_q = (mode_r == MODE_QUOTED);
  assign close_start = close_q ? FILL_W'(col_r) + 1'b1 : FILL_W'(col_inc);
  assign close_count = close_q ? col_r : col_inc;
  assign exp_ext = FILL_W'(exp_r);

  // Byte handling outside a row end: at most one result per byte.
  always_comb begin
    t_emit = 1'b0;
    t_kind = KIND_BYTE;
    t_byte = in_byte_value;
    t_mode = mode_r;
    t_adv  = 1'b0;
    if (mode_r == MODE_QUOTED) begin
      if (in_byte_value == BYTE_QUOTE) t_mode = MODE_AFTER_QUOTE;
      else t_emit = 1'b1;
    end else if (mode_r == MODE_SPACE && in_byte_value == BYTE_SPACE) begin
      t_mode = MODE_SPACE;
    end else if (in_byte_value == BYTE_COMMA) begin
      t_emit = 1'b1;
      t_kind = KIND_END;
      t_byte = 8'd0;
      t_adv  = 1'b1;
      t_mode = MODE_SPACE;
    end else if (in_byte_value == BYTE_QUOTE) begin
      t_emit = (mode_r == MODE_AFTER_QUOTE);
      t_mode = MODE_QUOTED;
    end else begin
      t_emit = 1'b1;
      t_mode = MODE_PLAIN;
    end
  end

  assign st.slot_ok    = !ov_r || !out_stall;
  assign st.close_req  = (in_byte_value == BYTE_NL) || in_end_of_stream;
  assign st.fill_after = hdr_seen_r && (close_start < exp_ext);
  assign st.fill_last  = (fill_col_r + 1'b1 >= exp_ext) ||
                         (run_r + 1'b1 == RUN_W'(RESULT_CAP));

  always_comb begin
    mode_nxt     = mode_r;
    col_nxt      = col_r;
    exp_nxt      = exp_r;
    hdr_seen_nxt = hdr_seen_r;
    fill_col_nxt = fill_col_r;
    run_nxt      = run_r;
    load         = 1'b0;
    e_kind       = t_kind;
    e_byte       = t_byte;
    e_idx        = COL_W'(col_idx);
    e_ovf        = col_sat;
    e_last       = !in_end_of_stream;
    if (cmd.take) begin
      // A newline goes straight to the row close.
      if (in_byte_value != BYTE_NL) begin
        mode_nxt = t_mode;
        if (t_adv) col_nxt = col_inc;
        load    = t_emit;
        run_nxt = RUN_W'(t_emit);
      end else begin
        run_nxt = '0;
      end
    end else if (cmd.close) begin
      load   = 1'b1;
      e_kind = close_q ? KIND_DROP : KIND_END;
      e_byte = 8'd0;
      e_last = !st.fill_after;
      run_nxt = run_r + 1'b1;
      if (hdr_seen_r) begin
        fill_col_nxt = close_start;
      end else begin
        exp_nxt      = close_count;
        hdr_seen_nxt = 1'b1;
      end
      col_nxt  = '0;
      mode_nxt = MODE_SPACE;
    end else if (cmd.fill) begin
      load   = 1'b1;
      e_kind = KIND_FILL;
      e_byte = 8'd0;
      e_idx  = COL_W'(fill_col_r);
      e_ovf  = 1'b0;
      e_last = st.fill_last;
      fill_col_nxt = fill_col_r + 1'b1;
      run_nxt      = run_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_SPACE;
      col_r      <= '0;
      exp_r      <= '0;
      hdr_seen_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      col_r      <= col_nxt;
      exp_r      <= exp_nxt;
      hdr_seen_r <= hdr_seen_nxt;
      if (load) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    fill_col_r <= fill_col_nxt;
    run_r      <= run_nxt;
    if (load) begin
      kind_r <= e_kind;
      byte_r <= e_byte;
      idx_r  <= e_idx;
      hdr_r  <= !hdr_seen_r;
      ovf_r  <= e_ovf;
      last_r <= e_last;
    end
  end

  assign out_valid           = ov_r;
  assign out_result_kind     = kind_r;
  assign out_field_byte      = byte_r;
  assign out_column_index    = idx_r;
  assign out_header_row      = hdr_r;
  assign out_column_overflow = ovf_r;
  assign out_last_of_run     = last_r;

endmodule
`default_nettype wire

@@ design/csv_field_tokenizer.sv @@
`default_nettype none
// Channel   Direction  Handshake          Word
// in_       input      in_valid/in_stall  byte_value, end_of_stream
// out_      output     out_valid/out_stall result_kind, field_byte, column_index,
//                                         header_row, column_overflow, last_of_run
//
// An ordinary byte (content, comma, quote, space) loads any result into the
// output register; unless out_stall holds it, the next byte enters the cycle
// after. A row end (newline or end_of_stream): take the byte and any content
// result, emit the field end or discard, then one fill per missing column.
// rst_n is synchronous, active low; it clears parse mode, columns and header flag.
// out_stall holds the output register and, through it, in_stall; nothing drops.
module csv_field_tokenizer #(
  parameter int MAX_COLUMNS = csvt_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_byte_value,
  input  wire logic                   in_end_of_stream,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_result_kind,
  output logic [7:0]                  out_field_byte,
  output logic [csvt_pkg::COL_W-1:0]  out_column_index,
  output logic                        out_header_row,
  output logic                        out_column_overflow,
  output logic                        out_last_of_run
);
  import csvt_pkg::*;

  // Commands from the sequencer, status back from the datapath.
  cmd_t    cmd;
  status_t st;

  // Sequencer: take a word, close the row, then walk the fill columns.
  csvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Datapath: parse mode, column counters, header width and output register.
  csvt_dp #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_byte_value       (in_byte_value),
    .in_end_of_stream    (in_end_of_stream),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_field_byte      (out_field_byte),
    .out_column_index    (out_column_index),
    .out_header_row      (out_header_row),
    .out_column_overflow (out_column_overflow),
    .out_last_of_run     (out_last_of_run)
  );

endmodule
`default_nettype wire

@@ design/csvt_checker.sv @@
`default_nettype none
module csvt_checker #(
  parameter int MAX_COLUMNS = csvt_pkg::MAX_COLUMNS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic [7:0]            in_byte_value,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [1:0]            out_result_kind,
  input wire logic [7:0]            out_field_byte,
  input wire logic [csvt_pkg::COL_W-1:0] out_column_index,
  input wire logic                  out_header_row,
  input wire logic                  out_column_overflow,
  input wire logic                  out_last_of_run
);
  import csvt_pkg::*;

  // Only content words carry a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_BYTE |-> out_field_byte == 8'd0)
    else $error("non-content word carries a byte");

  // Overflowed columns sit at the top index.
  a_ovf_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_column_overflow |->
      out_column_index == COL_W'(MAX_COLUMNS - 1))
    else $error("overflow word not at top column");

  // Fills come only after the header row is known.
  a_fill_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_FILL |-> !out_header_row)
    else $error("fill word in header row");

  // A newline word always stalls the input for the row close before the next input is taken.
  a_nl_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_byte_value == BYTE_NL |=> in_stall)
    else $error("input taken during row close");

  // Stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_column_index) && $stable(out_last_of_run))
    else $error("stalled output word changed");

endmodule

bind csv_field_tokenizer csvt_checker #(
  .MAX_COLUMNS (MAX_COLUMNS)
) u_csvt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_byte_value       (in_byte_value),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_result_kind     (out_result_kind),
  .out_field_byte      (out_field_byte),
  .out_column_index    (out_column_index),
  .out_header_row      (out_header_row),
  .out_column_overflow (out_column_overflow),
  .out_last_of_run     (out_last_of_run)
);
`default_nettype wire

@@ dv/csv_token_checker.sv @@
`timescale 1ns / 100ps

module csv_token_checker #(
  parameter int MAX_COLS = csvt_pkg::MAX_COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_end_of_stream,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_result_kind,
  input  logic [7:0] out_field_byte,
  input  logic [4:0] out_column_index,
  input  logic       out_header_row,
  input  logic       out_column_overflow,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         pending_words,
  output int         checked_words
);
  import csvt_pkg::*;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [COL_W-1:0] col;
    logic             hdr;
    logic             ovf;
    logic             last;
  } token_word_t;

  token_word_t token_q[$];
  token_word_t step_q[$];

  mode_t      mode;
  logic [6:0] col_cnt;
  logic [6:0] hdr_cols;
  logic       hdr_done;

  function automatic logic [6:0] bump_col(input logic [6:0] c);
    return (c >= MAX_COLS) ? 7'(MAX_COLS) : c + 7'd1;
  endfunction

  // Drop words beyond the per-byte cap.
  task automatic add_word(input kind_t kind, input logic [7:0] data, input logic [6:0] c);
    token_word_t w;
    if (step_q.size() >= RESULT_CAP) return;
    w.kind = kind;
    w.data = data;
    w.col  = (c >= MAX_COLS) ? COL_W'(MAX_COLS - 1) : c[COL_W-1:0];
    w.hdr  = !hdr_done;
    w.ovf  = (c >= MAX_COLS);
    w.last = 1'b0;
    step_q = {step_q, w};
  endtask

  task automatic close_row_pred();
    logic [6:0] fill_from;
    logic [6:0] row_cols;
    if (mode == MODE_QUOTED) begin
      // open quote: the discard word stands in for this column's fill
      add_word(KIND_DROP, 8'd0, col_cnt);
      fill_from = col_cnt + 7'd1;
      row_cols  = col_cnt;
    end else begin
      add_word(KIND_END, 8'd0, col_cnt);
      fill_from = bump_col(col_cnt);
      row_cols  = fill_from;
    end
    if (hdr_done) begin
      for (logic [6:0] c = fill_from; c < hdr_cols; c++) add_word(KIND_FILL, 8'd0, c);
    end else begin
      hdr_cols = row_cols;
      hdr_done = 1'b1;
    end
    col_cnt = '0;
    mode    = MODE_SPACE;
  endtask

  task automatic take_byte_pred(input logic [7:0] b);
    if (mode == MODE_QUOTED) begin
      if (b == BYTE_QUOTE) mode = MODE_AFTER_QUOTE;
      else add_word(KIND_BYTE, b, col_cnt);
      return;
    end
    if (mode == MODE_SPACE) begin
      if (b == BYTE_SPACE) return;
      mode = MODE_PLAIN;
    end
    if (b == BYTE_COMMA) begin
      add_word(KIND_END, 8'd0, col_cnt);
      col_cnt = bump_col(col_cnt);
      mode    = MODE_SPACE;
    end else if (b == BYTE_QUOTE) begin
      if (mode == MODE_AFTER_QUOTE) add_word(KIND_BYTE, b, col_cnt);
      mode = MODE_QUOTED;
    end else begin
      add_word(KIND_BYTE, b, col_cnt);
      mode = MODE_PLAIN;
    end
  endtask

  task automatic predict_tokens(input logic [7:0] b, input logic eos);
    step_q.delete();
    if (b == BYTE_NL) begin
      close_row_pred();
    end else begin
      take_byte_pred(b);
      if (eos) close_row_pred();
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    token_q = {token_q, step_q};
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    token_word_t want;
    if (!rst_n) begin
      token_q.delete();
      mode          = MODE_SPACE;
      col_cnt       = '0;
      hdr_cols      = '0;
      hdr_done      = 1'b0;
      fail_count    = 0;
      checked_words = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $error("result word with no expected word pending");
          fail_count++;
        end else begin
          want = token_q.pop_front();
          check_field("result_kind", want.kind, out_result_kind);
          check_field("field_byte", want.data, out_field_byte);
          check_field("column_index", want.col, out_column_index);
          check_field("header_row", want.hdr, out_header_row);
          check_field("column_overflow", want.ovf, out_column_overflow);
          check_field("last_of_run", want.last, out_last_of_run);
          checked_words++;
        end
      end
      if (in_valid && !in_stall) predict_tokens(in_byte_value, in_end_of_stream);
    end
    pending_words = token_q.size();
  end

endmodule

@@ dv/csv_field_tokenizer_test.sv @@
`timescale 1ns / 100ps

module csv_field_tokenizer_test;
  import csvt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  // random rows stop once this many non-space bytes have gone in
  localparam int BYTE_BUDGET = 450;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic [7:0] in_byte_value    = 8'd0;
  logic       in_end_of_stream = 1'b0;
  logic       out_stall        = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_result_kind;
  logic [7:0] out_field_byte;
  logic [4:0] out_column_index;
  logic       out_header_row;
  logic       out_column_overflow;
  logic       out_last_of_run;

  int fail_count;
  int pending_words;
  int checked_words;

  // sender/receiver knobs
  bit steady_in  = 1'b0;
  bit steady_out = 1'b0;
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;
  int hold_left  = 0;

  int bytes_sent = 0;
  int rows_sent  = 0;
  int cycles     = 0;

  always #4 clk = ~clk;

  csv_field_tokenizer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte_value       (in_byte_value),
    .in_end_of_stream    (in_end_of_stream),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_field_byte      (out_field_byte),
    .out_column_index    (out_column_index),
    .out_header_row      (out_header_row),
    .out_column_overflow (out_column_overflow),
    .out_last_of_run     (out_last_of_run)
  );

  csv_token_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte_value       (in_byte_value),
    .in_end_of_stream    (in_end_of_stream),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_field_byte      (out_field_byte),
    .out_column_index    (out_column_index),
    .out_header_row      (out_header_row),
    .out_column_overflow (out_column_overflow),
    .out_last_of_run     (out_last_of_run),
    .fail_count          (fail_count),
    .pending_words       (pending_words),
    .checked_words       (checked_words)
  );

  // Count cycles; end the run if it hangs.
  always @(posedge clk) cycles <= cycles + 1;

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request, and a quiet
  // stretch while steady_out is set. Drive at the falling edge.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !steady_out && ($urandom_range(99) < 14);
    end
  end

  // Offer one word; idle now and then unless steady_in is set. Called and
  // returns at a falling edge, with valid still high so back-to-back words
  // keep it high.
  task automatic send_word(input logic [7:0] b, input logic eos = 1'b0);
    while (!steady_in && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_byte_value    <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    // leading spaces are mostly skipped; leave all spaces out of the budget
    if (b != BYTE_SPACE) bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  // Drop valid and hold until every expected word has come out.
  task automatic drain_pause();
    in_valid <= 1'b0;
    wait (pending_words == 0);
    @(negedge clk);
  endtask

  // Plain content: anything but newline, comma and quote.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == BYTE_NL || b == BYTE_COMMA || b == BYTE_QUOTE);
    return b;
  endfunction

  // Quoted content: commas and spaces are fine, newline and quote are not.
  function automatic logic [7:0] quoted_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == BYTE_NL || b == BYTE_QUOTE);
    return b;
  endfunction

  // One mostly well-formed row with random content, plus some noise.
  task automatic send_row();
    int fields;
    int style;
    int len;
    fields = ($urandom_range(99) < 8) ? $urandom_range(30, 36) : $urandom_range(1, 6);
    for (int f = 0; f < fields; f++) begin
      if (f > 0) send_word(BYTE_COMMA);
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) send_word(BYTE_SPACE);
      style = $urandom_range(9);
      if (style < 5) begin
        repeat ($urandom_range(4)) send_word(plain_byte());
      end else if (style < 8) begin
        send_word(BYTE_QUOTE);
        len = $urandom_range(4);
        repeat (len) begin
          if ($urandom_range(5) == 0) begin
            // doubled quote -> literal quote
            send_word(BYTE_QUOTE);
            send_word(BYTE_QUOTE);
          end else begin
            send_word(quoted_byte());
          end
        end
        send_word(BYTE_QUOTE);
        // stray byte after the closing quote drops back to plain
        if ($urandom_range(3) == 0) send_word(plain_byte());
      end else if (style == 9) begin
        // noise: any byte, newline and quote included, rare end of stream
        repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(255)), $urandom_range(99) == 0);
      end
    end
    case ($urandom_range(11))
      0: send_word(BYTE_NL, 1'b1);
      1: send_word(plain_byte(), 1'b1);
      2: begin
        // leave a quote open across the row end
        send_word(BYTE_QUOTE);
        send_word(quoted_byte());
        send_word(BYTE_NL);
      end
      default: send_word(BYTE_NL);
    endcase
    rows_sent++;
  endtask

  initial begin : stimulus
    int row_no;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Header row, 34 fields so the column count saturates at 32. Field 0
    // has leading spaces, a quoted comma, a doubled quote and a space after
    // the closing quote; field 1 carries the byte extremes and a CR.
    send_text("  \"a,\"\"b\" ,");
    send_word(8'hFF);
    send_word(8'h00);
    send_word(8'h0D);
    send_word(BYTE_COMMA);
    repeat (31) send_word(BYTE_COMMA);
    send_text("z\n");
    rows_sent++;

    // empty line: one empty field, then fills
    send_text("\n");
    // quote still open at the row end: discard word in place of field end
    send_text("q,\"open\n");
    // other byte after a closing quote: back to plain
    send_text("\"x\"y\n");
    // end of stream on a lone content byte: 33 words capped at 32
    send_word("w", 1'b1);
    // end of stream on a newline closes the row once
    send_text("k");
    send_word(BYTE_NL, 1'b1);
    // end of stream on a comma
    send_word(BYTE_COMMA, 1'b1);
    rows_sent += 6;

    drain_pause();

    row_no = 0;
    while (bytes_sent < BYTE_BUDGET) begin
      // long receiver hold-off while the sender keeps offering
      if (row_no == 3) hold_req <= 1'b1;
      // quiet stretch on both sides
      steady_in = (row_no >= 6 && row_no < 13);
      steady_out <= (row_no >= 6 && row_no < 13);
      // sender waits for the pipe to empty once mid-run
      if (row_no == 14) drain_pause();
      send_row();
      row_no++;
    end

    in_valid <= 1'b0;
    wait (pending_words == 0);
    repeat (40) @(posedge clk);

    $display("Sent %0d bytes in %0d rows (header, quotes, overflow, end of stream, fills)",
             bytes_sent, rows_sent);
    $display("Checked %0d result words, %0d mismatches", checked_words, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
